// File: sv/irclt_pkg.sv
package irclt_pkg;

   localparam int ParamIndexBits = 8;

   localparam logic [7:0] CharColon = 8'h3a;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowZ  = 8'h7a;
   localparam logic [7:0] CaseDelta = 8'h20;

   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_PREFIX = 3'd1;
   localparam logic [2:0] KIND_CMD    = 3'd2;
   localparam logic [2:0] KIND_MIDDLE = 3'd3;
   localparam logic [2:0] KIND_TRAIL  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_line;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [2:0] field_kind;
      logic [7:0] param_index;
      logic       new_field;
      logic       message_end;
      logic       malformed;
      logic       too_many_params;
   } result_type;

   function automatic logic [7:0] upcase(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= CharLowA && b <= CharLowZ) begin
         r = b - CaseDelta;
      end
      return r;
   endfunction

endpackage

// File: sv/irclt_parse.sv
module irclt_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  irclt_pkg::item_type   item,
   output irclt_pkg::result_type result
);

   localparam logic [2:0] M_LINE_START = 3'd0;
   localparam logic [2:0] M_PREFIX     = 3'd1;
   localparam logic [2:0] M_CMD_START  = 3'd2;
   localparam logic [2:0] M_CMD        = 3'd3;
   localparam logic [2:0] M_GAP        = 3'd4;
   localparam logic [2:0] M_MIDDLE     = 3'd5;
   localparam logic [2:0] M_TRAILING   = 3'd6;

   localparam logic [irclt_pkg::ParamIndexBits-1:0] CountMax = '1;

   logic [2:0]                           mode_ff, mode_in;
   logic [irclt_pkg::ParamIndexBits-1:0] count_ff, count_in;
   logic                                 sat_ff, sat_in;

   logic [2:0]                           mode_b;
   logic [irclt_pkg::ParamIndexBits-1:0] count_b;
   logic                                 sat_b;
   logic [7:0]                           b;
   logic [7:0]                           idx8;

   assign b    = item.data_byte;
   assign idx8 = 8'(count_ff);

   always_comb begin
      mode_b  = mode_ff;
      count_b = count_ff;
      sat_b   = sat_ff;
      result  = '0;
      if (item.has_byte) begin
         result.out_byte = b;
         case (mode_ff)
            M_LINE_START, M_CMD_START: begin
               if (mode_ff == M_LINE_START && b == irclt_pkg::CharColon) begin
                  mode_b            = M_PREFIX;
                  result.field_kind = irclt_pkg::KIND_PREFIX;
                  result.new_field  = 1'b1;
               end else begin
                  result.field_kind = irclt_pkg::KIND_CMD;
                  result.new_field  = 1'b1;
                  if (b == irclt_pkg::CharSpace) begin
                     mode_b = M_GAP;
                  end else begin
                     mode_b            = M_CMD;
                     result.byte_valid = 1'b1;
                     result.out_byte   = irclt_pkg::upcase(b);
                  end
               end
            end
            M_PREFIX: begin
               if (b == irclt_pkg::CharSpace) begin
                  mode_b = M_CMD_START;
               end else begin
                  result.field_kind = irclt_pkg::KIND_PREFIX;
                  result.byte_valid = 1'b1;
               end
            end
            M_CMD: begin
               if (b == irclt_pkg::CharSpace) begin
                  mode_b = M_GAP;
               end else begin
                  result.field_kind = irclt_pkg::KIND_CMD;
                  result.byte_valid = 1'b1;
                  result.out_byte   = irclt_pkg::upcase(b);
               end
            end
            M_GAP: begin
               if (b == irclt_pkg::CharColon) begin
                  mode_b             = M_TRAILING;
                  result.field_kind  = irclt_pkg::KIND_TRAIL;
                  result.new_field   = 1'b1;
                  result.param_index = idx8;
               end else if (b != irclt_pkg::CharSpace) begin
                  mode_b             = M_MIDDLE;
                  result.field_kind  = irclt_pkg::KIND_MIDDLE;
                  result.new_field   = 1'b1;
                  result.byte_valid  = 1'b1;
                  result.param_index = idx8;
               end
            end
            M_MIDDLE: begin
               if (b == irclt_pkg::CharSpace) begin
                  mode_b = M_GAP;
                  if (count_ff == CountMax) begin
                     sat_b = 1'b1;
                  end else begin
                     count_b = count_ff + 1'b1;
                  end
               end else begin
                  result.field_kind  = irclt_pkg::KIND_MIDDLE;
                  result.byte_valid  = 1'b1;
                  result.param_index = idx8;
               end
            end
            default: begin
               result.field_kind  = irclt_pkg::KIND_TRAIL;
               result.byte_valid  = 1'b1;
               result.param_index = idx8;
            end
         endcase
      end

      result.too_many_params = sat_b;
      result.message_end     = item.end_of_line;

      mode_in  = mode_b;
      count_in = count_b;
      sat_in   = sat_b;
      if (item.end_of_line) begin
         if (mode_b == M_PREFIX) begin
            result.malformed = 1'b1;
         end else if (mode_b == M_CMD_START) begin
            result.field_kind = irclt_pkg::KIND_CMD;
            result.new_field  = 1'b1;
            result.byte_valid = 1'b0;
         end
         mode_in  = M_LINE_START;
         count_in = '0;
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_LINE_START;
         count_ff <= '0;
         sat_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

// File: sv/irc_line_tokenizer.sv
// irc line tokenizer: tags each byte of an irc protocol line with its field
// req channel: one word per line byte; req_tdata is the byte, req_tuser
//   says whether the word carries a byte, req_tlast marks the word that
//   ends the line (after its byte, or alone with req_tuser low)
// rsp channel: exactly one word per req word, in order; rsp_tuser is the
//   field kind, rsp_tlast marks the end of the line, rsp_tdata carries the
//   (command upper-cased) byte, flags and parameter index
// path: each req word is held in an input register, parsed, and then held in
//   the result register, which drives the rsp channel
// throughput: one word per cycle while rsp_tready stays high; the parse state
//   updates as each word moves from the input register to the result register
// a stalled rsp_tready holds the result register; the input register keeps
//   one more word, then req_tready drops until the result is taken
// reset clears both register valids and returns the parser to line start
module irc_line_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // has_byte[0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_byte[7:0], byte_valid[8], param_index[16:9],
                                    // new_field[17], malformed[18], too_many_params[19],
                                    // zero[23:20]
   output logic [2:0]  rsp_tuser,   // field_kind[2:0]
   output logic        rsp_tlast
);

   irclt_pkg::item_type   item_ff, item_in;
   logic                  item_valid_ff, item_valid_in;
   irclt_pkg::result_type res_ff, res_in, res_comb;
   logic                  res_valid_ff, res_valid_in;
   logic                  out_free;
   logic                  advance;
   logic                  req_fire;

   assign out_free   = !res_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   irclt_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .result (res_comb)
   );

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !advance;
      if (req_fire) begin
         item_in.data_byte   = req_tdata;
         item_in.has_byte    = req_tuser;
         item_in.end_of_line = req_tlast;
         item_valid_in       = 1'b1;
      end
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !rsp_tready;
      if (advance) begin
         res_in       = res_comb;
         res_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {4'b0, res_ff.too_many_params, res_ff.malformed, res_ff.new_field,
                        res_ff.param_index, res_ff.byte_valid, res_ff.out_byte};
   assign rsp_tuser  = res_ff.field_kind;
   assign rsp_tlast  = res_ff.message_end;

endmodule

// File: test/irc_line_tokenizer_test.sv
module irc_line_tokenizer_test;

   localparam int WordsWanted = 1750;
   localparam int QuietLimit  = 200;

   localparam logic [2:0] AT_LINE_START = 3'd0;
   localparam logic [2:0] IN_PREFIX     = 3'd1;
   localparam logic [2:0] CMD_START     = 3'd2;
   localparam logic [2:0] IN_CMD        = 3'd3;
   localparam logic [2:0] IN_GAP        = 3'd4;
   localparam logic [2:0] IN_MIDDLE     = 3'd5;
   localparam logic [2:0] IN_TRAILING   = 3'd6;

   typedef struct {
      irclt_pkg::item_type   word;
      bit                    typed;
      irclt_pkg::result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [2:0]                           scan_mode = AT_LINE_START;
   logic [irclt_pkg::ParamIndexBits-1:0] param_count = '0;
   logic                                 count_full = 1'b0;

   irclt_pkg::result_type pending_tags[$];
   stim_row_type          script[$];
   irclt_pkg::item_type   line_words[$];
   int         failures = 0;
   int         words_sent = 0;
   int         quiet_cycles = 0;
   bit         req_calm = 1'b0;
   bit         rsp_calm = 1'b0;

   irc_line_tokenizer uut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .req_tlast,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tuser,
      .rsp_tlast
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] cased(input logic [7:0] b);
      if (b >= irclt_pkg::CharLowA && b <= irclt_pkg::CharLowZ) begin
         return {b[7:6], 1'b0, b[4:0]};
      end
      return b;
   endfunction

   function automatic irclt_pkg::result_type tokenize(input irclt_pkg::item_type w);
      irclt_pkg::result_type r;
      logic [7:0] b;
      b = w.data_byte;
      r = '0;
      if (w.has_byte) begin
         r.out_byte = b;
         case (scan_mode)
            AT_LINE_START, CMD_START: begin
               if (scan_mode == AT_LINE_START && b == irclt_pkg::CharColon) begin
                  scan_mode = IN_PREFIX;
                  r.field_kind = irclt_pkg::KIND_PREFIX;
                  r.new_field = 1'b1;
               end else begin
                  r.field_kind = irclt_pkg::KIND_CMD;
                  r.new_field = 1'b1;
                  if (b == irclt_pkg::CharSpace) begin
                     scan_mode = IN_GAP;
                  end else begin
                     scan_mode = IN_CMD;
                     r.byte_valid = 1'b1;
                     r.out_byte = cased(b);
                  end
               end
            end
            IN_PREFIX: begin
               if (b == irclt_pkg::CharSpace) begin
                  scan_mode = CMD_START;
               end else begin
                  r.field_kind = irclt_pkg::KIND_PREFIX;
                  r.byte_valid = 1'b1;
               end
            end
            IN_CMD: begin
               if (b == irclt_pkg::CharSpace) begin
                  scan_mode = IN_GAP;
               end else begin
                  r.field_kind = irclt_pkg::KIND_CMD;
                  r.byte_valid = 1'b1;
                  r.out_byte = cased(b);
               end
            end
            IN_GAP: begin
               if (b == irclt_pkg::CharColon) begin
                  scan_mode = IN_TRAILING;
                  r.field_kind = irclt_pkg::KIND_TRAIL;
                  r.new_field = 1'b1;
                  r.param_index = 8'(param_count);
               end else if (b != irclt_pkg::CharSpace) begin
                  scan_mode = IN_MIDDLE;
                  r.field_kind = irclt_pkg::KIND_MIDDLE;
                  r.new_field = 1'b1;
                  r.byte_valid = 1'b1;
                  r.param_index = 8'(param_count);
               end
            end
            IN_MIDDLE: begin
               if (b == irclt_pkg::CharSpace) begin
                  scan_mode = IN_GAP;
                  if (&param_count) begin
                     count_full = 1'b1;
                  end else begin
                     param_count = param_count + 1'b1;
                  end
               end else begin
                  r.field_kind = irclt_pkg::KIND_MIDDLE;
                  r.byte_valid = 1'b1;
                  r.param_index = 8'(param_count);
               end
            end
            default: begin
               r.field_kind = irclt_pkg::KIND_TRAIL;
               r.byte_valid = 1'b1;
               r.param_index = 8'(param_count);
            end
         endcase
      end
      r.too_many_params = count_full;
      if (w.end_of_line) begin
         r.message_end = 1'b1;
         if (scan_mode == IN_PREFIX) begin
            r.malformed = 1'b1;
         end else if (scan_mode == CMD_START) begin
            r.field_kind = irclt_pkg::KIND_CMD;
            r.new_field = 1'b1;
            r.byte_valid = 1'b0;
         end
         scan_mode = AT_LINE_START;
         param_count = '0;
         count_full = 1'b0;
      end
      return r;
   endfunction

   function automatic irclt_pkg::result_type typed_tag(input logic [7:0] ob, input logic v,
                                                       input logic [2:0] k,
                                                       input logic [7:0] idx,
                                                       input logic nf, input logic me,
                                                       input logic mal, input logic sat);
      irclt_pkg::result_type r;
      r.out_byte = ob;
      r.byte_valid = v;
      r.field_kind = k;
      r.param_index = idx;
      r.new_field = nf;
      r.message_end = me;
      r.malformed = mal;
      r.too_many_params = sat;
      return r;
   endfunction

   function automatic void match_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want != got) begin
         failures++;
         $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      end
   endfunction

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do begin
         if ($urandom_range(0, 1)) begin
            b = 8'($urandom_range(0, 25))
                + ($urandom_range(0, 1) ? irclt_pkg::CharLowA : 8'h41);
         end else begin
            b = 8'($urandom_range(0, 255));
         end
      end while (b == irclt_pkg::CharSpace);
      return b;
   endfunction

   task automatic row(input logic [7:0] b, input logic h, input logic e,
                      input bit typed = 1'b0, input irclt_pkg::result_type want = '0);
      stim_row_type s;
      s.word = '{b, h, e};
      s.typed = typed;
      s.want = want;
      script = {script, s};
   endtask

   task automatic send_word(input irclt_pkg::item_type w, input bit typed,
                            input irclt_pkg::result_type want);
      int gap;
      irclt_pkg::result_type got_tag;
      gap = req_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w.data_byte;
      req_tuser <= w.has_byte;
      req_tlast <= w.end_of_line;
      do @(posedge clock); while (req_tready !== 1'b1);
      got_tag = tokenize(w);
      if (typed) got_tag = want;
      pending_tags = {pending_tags, got_tag};
   endtask

   task automatic put(input logic [7:0] b);
      irclt_pkg::item_type w;
      if ($urandom_range(0, 19) == 0) begin
         w = '{8'($urandom_range(0, 255)), 1'b0, 1'b0};
         line_words = {line_words, w};
      end
      w = '{b, 1'b1, 1'b0};
      line_words = {line_words, w};
   endtask

   task automatic close_line();
      irclt_pkg::item_type w;
      if (line_words.size() > 0 && line_words[line_words.size() - 1].has_byte
          && $urandom_range(0, 1) == 1) begin
         line_words[line_words.size() - 1].end_of_line = 1'b1;
      end else begin
         w = '{8'($urandom_range(0, 255)), 1'b0, 1'b1};
         line_words = {line_words, w};
      end
   endtask

   task automatic send_line();
      foreach (line_words[i]) begin
         send_word(line_words[i], 1'b0, '0);
         words_sent++;
      end
      line_words.delete();
   endtask

   initial begin : stimulus
      logic [7:0] b;
      int pick;
      irclt_pkg::item_type w;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty line, idle word
      row(8'h00, 1'b0, 1'b1, 1'b1, typed_tag(8'h00, 1'b0, irclt_pkg::KIND_NONE, 8'd0,
                                             1'b0, 1'b1, 1'b0, 1'b0));
      row(8'hff, 1'b0, 1'b0, 1'b1, typed_tag(8'h00, 1'b0, irclt_pkg::KIND_NONE, 8'd0,
                                             1'b0, 1'b0, 1'b0, 1'b0));
      // prefix, command with colon and case edges, middle, trailing
      row(irclt_pkg::CharColon, 1'b1, 1'b0, 1'b1,
          typed_tag(irclt_pkg::CharColon, 1'b0, irclt_pkg::KIND_PREFIX, 8'd0,
                    1'b1, 1'b0, 1'b0, 1'b0));
      row(8'h6e, 1'b1, 1'b0);
      row(irclt_pkg::CharSpace, 1'b1, 1'b0);
      row(8'h61, 1'b1, 1'b0, 1'b1, typed_tag(8'h41, 1'b1, irclt_pkg::KIND_CMD, 8'd0,
                                             1'b1, 1'b0, 1'b0, 1'b0));
      row(irclt_pkg::CharColon, 1'b1, 1'b0);
      row(8'h7a, 1'b1, 1'b0);
      row(8'h7b, 1'b1, 1'b0);
      row(8'h60, 1'b1, 1'b0);
      row(irclt_pkg::CharSpace, 1'b1, 1'b0);
      row(8'hff, 1'b1, 1'b0);
      row(irclt_pkg::CharSpace, 1'b1, 1'b0);
      row(irclt_pkg::CharSpace, 1'b1, 1'b0);
      row(irclt_pkg::CharColon, 1'b1, 1'b0);
      row(irclt_pkg::CharSpace, 1'b1, 1'b0);
      row(8'h00, 1'b1, 1'b1, 1'b1, typed_tag(8'h00, 1'b1, irclt_pkg::KIND_TRAIL, 8'd1,
                                             1'b0, 1'b1, 1'b0, 1'b0));
      // prefix without space
      row(irclt_pkg::CharColon, 1'b1, 1'b0);
      row(8'h78, 1'b1, 1'b1, 1'b1, typed_tag(8'h78, 1'b1, irclt_pkg::KIND_PREFIX, 8'd0,
                                             1'b0, 1'b1, 1'b1, 1'b0));
      // empty command closed by end of line
      row(irclt_pkg::CharColon, 1'b1, 1'b0);
      row(irclt_pkg::CharSpace, 1'b1, 1'b0);
      row(8'h00, 1'b0, 1'b1, 1'b1, typed_tag(8'h00, 1'b0, irclt_pkg::KIND_CMD, 8'd0,
                                             1'b1, 1'b1, 1'b0, 1'b0));
      // empty command on a leading space, empty trailing
      row(irclt_pkg::CharSpace, 1'b1, 1'b0);
      row(irclt_pkg::CharColon, 1'b1, 1'b0);
      row(8'h00, 1'b0, 1'b1);
      foreach (script[i]) send_word(script[i].word, script[i].typed, script[i].want);

      // enough middle params to saturate the index
      put(8'h63);
      for (int k = 0; k < 262; k++) begin
         put(irclt_pkg::CharSpace);
         put(8'h70);
      end
      put(irclt_pkg::CharSpace);
      put(irclt_pkg::CharColon);
      put(8'h78);
      close_line();
      send_line();

      while (words_sent < WordsWanted) begin
         if ($urandom_range(0, 9) == 0) req_calm = !req_calm;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 1)) begin
               put(irclt_pkg::CharColon);
               repeat ($urandom_range(1, 6)) put(text_byte());
               repeat ($urandom_range(1, 2)) put(irclt_pkg::CharSpace);
            end
            repeat ($urandom_range(0, 6)) put(text_byte());
            repeat ($urandom_range(0, 5)) begin
               repeat ($urandom_range(1, 3)) put(irclt_pkg::CharSpace);
               do b = text_byte(); while (b == irclt_pkg::CharColon);
               put(b);
               repeat ($urandom_range(0, 5)) put(text_byte());
            end
            if ($urandom_range(0, 1)) begin
               repeat ($urandom_range(1, 2)) put(irclt_pkg::CharSpace);
               put(irclt_pkg::CharColon);
               repeat ($urandom_range(0, 8)) put(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 3) == 0) begin
               put(irclt_pkg::CharSpace);
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(0, 12)) begin
               w = '{8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) != 0), 1'b0};
               line_words = {line_words, w};
            end
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  put(irclt_pkg::CharColon);
                  repeat ($urandom_range(0, 5)) put(text_byte());
               end
               1: begin
                  repeat ($urandom_range(1, 4)) put(irclt_pkg::CharSpace);
               end
               default: begin
                  put(irclt_pkg::CharColon);
                  put(irclt_pkg::CharSpace);
               end
            endcase
         end
         close_line();
         send_line();
      end

      req_tvalid <= 1'b0;
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : drain
      int stall;
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && !reset));
      end
   end

   // result word check
   always @(posedge clock) begin
      irclt_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tags.size() == 0) begin
            failures++;
            $display("%0t: unexpected word, expected none got data %h user %h last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_tags.pop_front();
            match_field("out_byte", want.out_byte, rsp_tdata[7:0]);
            match_field("byte_valid", 8'(want.byte_valid), 8'(rsp_tdata[8]));
            match_field("field_kind", 8'(want.field_kind), 8'(rsp_tuser));
            match_field("param_index", want.param_index, rsp_tdata[16:9]);
            match_field("new_field", 8'(want.new_field), 8'(rsp_tdata[17]));
            match_field("message_end", 8'(want.message_end), 8'(rsp_tlast));
            match_field("malformed", 8'(want.malformed), 8'(rsp_tdata[18]));
            match_field("too_many_params", 8'(want.too_many_params), 8'(rsp_tdata[19]));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QuietLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
